// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files that check their own logic
// expects signals named clock and reset (active high) in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bgbp_pkg.sv =====
// package for the bimodal / gselect branch predictor
// types and fixed constants shared by the interfaces and the rtl modules other than bgbp_ram
package bgbp_pkg;

   // payload widths fixed by the item format
   localparam int ADDR_W     = 64;
   localparam int CFG_W      = 4;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   // width of bit counts; the configured index width stays at or below 15
   localparam int BITCNT_W   = 5;

   // two-bit saturating counter
   localparam int CNT_W = 2;
   localparam logic [CNT_W-1:0] CNT_RESET = 2'b01;
   localparam logic [CNT_W-1:0] CNT_MAX   = 2'b11;
   localparam logic [CNT_W-1:0] CNT_MIN   = 2'b00;

   // fall-through distance
   localparam logic [ADDR_W-1:0] INSTR_BYTES = 64'd4;
   // pc bits below the index
   localparam int PC_SHIFT = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd2;

   // predictor modes
   localparam logic [MODE_W-1:0] MODE_BIMODAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ZERO    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GSELECT = 2'd2;

   // response queue
   localparam int RSP_Q_DEPTH = 3;
   localparam int RSP_Q_PTR_W = 2;
   localparam int RSP_Q_CNT_W = 2;

   typedef struct packed {
      logic [ADDR_W-1:0] predicted_address;
      logic              predicted_taken;
      logic              config_error;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0]  index_bits;
      logic [CFG_W-1:0]  history_bits;
      logic [MODE_W-1:0] mode;
   } cfg_type;

endpackage

// ===== hw/rtl/bgbp_ifs.sv =====
// valid/ready channel interfaces of the branch predictor
// depends on bgbp_pkg for payload widths
interface bgbp_req_if import bgbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] pc_address;
   logic [ADDR_W-1:0] next_pc_address;

   modport source (output valid, output pc_address, output next_pc_address, input ready);
   modport sink   (input valid, input pc_address, input next_pc_address, output ready);
endinterface

interface bgbp_rsp_if import bgbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] predicted_address;
   logic              predicted_taken;
   logic              config_error;

   modport source (output valid, output predicted_address, output predicted_taken,
                   output config_error, input ready);
   modport sink   (input valid, input predicted_address, input predicted_taken,
                   input config_error, output ready);
endinterface

interface bgbp_csr_if import bgbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bgbp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// read-first on a same-address read and write; no dependencies
module bgbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/bgbp_index.sv =====
// table index and global history update for one branch item
// depends on bgbp_pkg for modes and field widths
module bgbp_index import bgbp_pkg::*; #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  cfg_type                    cfg,
   input  logic [ADDR_W-1:0]          pc_address,
   input  logic                       taken,
   input  logic [MAX_INDEX_BITS-1:0]  history,
   output logic [MAX_INDEX_BITS-1:0]  index,
   output logic                       config_error,
   output logic                       history_we,
   output logic [MAX_INDEX_BITS-1:0]  history_next
);

   localparam logic [BITCNT_W-1:0] MAX_IB = BITCNT_W'(MAX_INDEX_BITS);

   logic [BITCNT_W-1:0]       ib_raw;
   logic [BITCNT_W-1:0]       hb_raw;
   logic [BITCNT_W-1:0]       ib_eff;
   logic [BITCNT_W-1:0]       hb_eff;
   logic [MAX_INDEX_BITS-1:0] pc_bits;
   logic [MAX_INDEX_BITS-1:0] ib_mask;
   logic [MAX_INDEX_BITS-1:0] hb_mask;

   function automatic logic [MAX_INDEX_BITS-1:0] low_mask(input logic [BITCNT_W-1:0] n);
      return ~({MAX_INDEX_BITS{1'b1}} << n);
   endfunction

   // effective widths: index saturates, history limited to index
   assign ib_raw = BITCNT_W'(cfg.index_bits);
   assign hb_raw = BITCNT_W'(cfg.history_bits);
   assign ib_eff = (ib_raw > MAX_IB) ? MAX_IB : ib_raw;
   assign hb_eff = (hb_raw > ib_eff) ? ib_eff : hb_raw;
   assign ib_mask = low_mask(ib_eff);
   assign hb_mask = low_mask(hb_eff);
   assign pc_bits = pc_address[MAX_INDEX_BITS+PC_SHIFT-1:PC_SHIFT];

   // gselect with history wider than the index is rejected
   assign config_error = (cfg.mode == MODE_GSELECT) && (cfg.history_bits > cfg.index_bits);

   // index select per mode
   always_comb begin
      case (cfg.mode)
         MODE_BIMODAL: index = pc_bits & ib_mask;
         MODE_GSELECT: index = ((pc_bits << hb_eff) & ib_mask) | (history & hb_mask);
         default:      index = '0;
      endcase
   end

   // outcome shifts into the history in gselect mode with a nonzero history width and no config error
   assign history_we   = (cfg.mode == MODE_GSELECT) && (hb_eff != '0) && !config_error;
   assign history_next = ((history << 1) | MAX_INDEX_BITS'(taken)) & hb_mask;

endmodule

// ===== hw/rtl/bgbp_rsp_queue.sv =====
// three-entry result queue that decouples the table pipeline from the receiver
// depends on bgbp_pkg for the result item type and queue sizes
module bgbp_rsp_queue import bgbp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsp_item_type           push_item,
   input  logic                   pop,
   output logic                   not_empty,
   output rsp_item_type           head_item,
   output logic [RSP_Q_CNT_W-1:0] count
);

   localparam logic [RSP_Q_PTR_W-1:0] LAST_PTR = RSP_Q_PTR_W'(RSP_Q_DEPTH - 1);

   rsp_item_type             entry_ff [RSP_Q_DEPTH];
   logic [RSP_Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_Q_CNT_W-1:0]   count_ff, count_in;

   function automatic logic [RSP_Q_PTR_W-1:0] bump(input logic [RSP_Q_PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + RSP_Q_CNT_W'(push) - RSP_Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== hw/rtl/bimodal_gselect_branch_predictor_top.sv =====
// top level of the bimodal / gselect two-bit counter branch predictor
// depends on bgbp_pkg, bgbp_ifs, bgbp_ram, bgbp_index, bgbp_rsp_queue, assert_macros.svh
//
// req_chan takes one resolved branch per item (pc_address, next_pc_address);
// rsp_chan returns one item per branch (predicted_address, predicted_taken,
// config_error), in order. csr_chan writes index_bits (0), history_bits (1) and
// mode (2); it is always ready and writes to other indexes are dropped.
// The counter ram is read at the request accept edge; the counter update and the
// result item are formed in the next cycle and land in the result queue, and rsp
// valid follows from the registered queue fill count. One item per cycle is
// sustained while the receiver keeps taking results; the counter
// read-modify-write forwards the value written in the cycle before, and the
// history updates at accept so back-to-back gselect items see it.
// After reset the counter ram is swept to weakly not taken, one entry per
// cycle, all 2**MAX_INDEX_BITS entries (4096 by default); req ready stays low
// during the sweep. When the receiver stalls, results collect in a
// three-entry queue and req ready drops once it cannot take more.
module bimodal_gselect_branch_predictor_top import bgbp_pkg::*; #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   bgbp_req_if.sink     req_chan,
   bgbp_rsp_if.source   rsp_chan,
   bgbp_csr_if.sink     csr_chan
);

`include "assert_macros.svh"

   localparam int IW    = MAX_INDEX_BITS;
   localparam int DEPTH = 1 << MAX_INDEX_BITS;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_INDEX_BITS:   cfg_ff.index_bits   <= csr_chan.data;
            CSR_HISTORY_BITS: cfg_ff.history_bits <= csr_chan.data;
            CSR_MODE:         cfg_ff.mode         <= csr_chan.data[MODE_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // accept and outcome of the incoming branch
   logic              req_acc;
   logic              q_not_empty;
   logic [RSP_Q_CNT_W-1:0] q_count;
   logic              clr_busy_ff;
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] fall_through;
   logic              taken;

   assign req_chan.ready = !clr_busy_ff &&
      (({1'b0, q_count} + (RSP_Q_CNT_W+1)'(s1_valid_ff)) < (RSP_Q_CNT_W+1)'(RSP_Q_DEPTH));
   assign req_acc      = req_chan.valid && req_chan.ready;
   assign fall_through = req_chan.pc_address + INSTR_BYTES;
   assign taken        = (req_chan.next_pc_address != fall_through);

   // index and history
   logic [IW-1:0] hist_ff;
   logic [IW-1:0] hist_next;
   logic [IW-1:0] rd_index;
   logic          index_err;
   logic          hist_we;

   bgbp_index #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_index (
      .cfg          (cfg_ff),
      .pc_address   (req_chan.pc_address),
      .taken        (taken),
      .history      (hist_ff),
      .index        (rd_index),
      .config_error (index_err),
      .history_we   (hist_we),
      .history_next (hist_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (req_acc && hist_we) begin
         hist_ff <= hist_next;
      end
   end

   // stage one: item waiting for its counter read
   logic              s1_err_ff;
   logic              s1_taken_ff;
   logic [IW-1:0]     s1_idx_ff;
   logic [ADDR_W-1:0] s1_next_ff;
   logic [ADDR_W-1:0] s1_fall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_err_ff   <= index_err;
         s1_taken_ff <= taken;
         s1_idx_ff   <= rd_index;
         s1_next_ff  <= req_chan.next_pc_address;
         s1_fall_ff  <= fall_through;
      end
   end

   // clearing sweep after reset
   logic [IW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {IW{1'b1}}) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // counter read, forward and saturating update
   logic [CNT_W-1:0] ram_rdata;
   logic [CNT_W-1:0] cnt_cur;
   logic [CNT_W-1:0] cnt_new;
   logic             upd_we;
   logic             fwd_valid_ff;
   logic [IW-1:0]    fwd_idx_ff;
   logic [CNT_W-1:0] fwd_data_ff;
   logic             ram_we;
   logic [IW-1:0]    ram_waddr;
   logic [CNT_W-1:0] ram_wdata;

   assign cnt_cur = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_data_ff : ram_rdata;
   assign upd_we  = s1_valid_ff && !s1_err_ff;

   always_comb begin
      if (s1_taken_ff) begin
         cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
      end else begin
         cnt_new = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - 1'b1;
      end
   end

   // remember the write that lands with the next read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= upd_we;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         fwd_idx_ff  <= s1_idx_ff;
         fwd_data_ff <= cnt_new;
      end
   end

   assign ram_we    = clr_busy_ff || upd_we;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wdata = clr_busy_ff ? CNT_RESET : cnt_new;

   bgbp_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_counter_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_acc),
      .raddr (rd_index),
      .rdata (ram_rdata)
   );

   // result item and queue
   rsp_item_type s1_item;
   rsp_item_type head_item;
   logic         rsp_pop;

   always_comb begin
      if (s1_err_ff) begin
         s1_item.predicted_address = '0;
         s1_item.predicted_taken   = 1'b0;
         s1_item.config_error      = 1'b1;
      end else begin
         s1_item.predicted_address = cnt_cur[1] ? s1_next_ff : s1_fall_ff;
         s1_item.predicted_taken   = cnt_cur[1];
         s1_item.config_error      = 1'b0;
      end
   end

   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   bgbp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (s1_item),
      .pop       (rsp_pop),
      .not_empty (q_not_empty),
      .head_item (head_item),
      .count     (q_count)
   );

   assign rsp_chan.valid             = q_not_empty;
   assign rsp_chan.predicted_address = head_item.predicted_address;
   assign rsp_chan.predicted_taken   = head_item.predicted_taken;
   assign rsp_chan.config_error      = head_item.config_error;

   // checks
   `ASSERT_NOW(a_queue_room, s1_valid_ff && !rsp_pop,
      q_count < RSP_Q_CNT_W'(RSP_Q_DEPTH), "result queue overflow")
   `ASSERT_NOW(a_err_no_write, s1_valid_ff && s1_err_ff && !clr_busy_ff,
      !ram_we, "rejected item wrote the counter table")
   `ASSERT_NEXT(a_hist_hold, !req_acc, $stable(hist_ff), "history changed without an item")

endmodule
